/* rtl/core/bssc_pkg.sv */
// Shared types, codes and lookup functions for the six-step start-up controller.
`timescale 1ns / 1ps

package bssc_pkg;

  typedef enum logic [3:0] {
    MODE_IDLE     = 4'b0001,
    MODE_STARTING = 4'b0010,
    MODE_RUNNING  = 4'b0100,
    MODE_FAULT    = 4'b1000
  } mode_e;

  localparam logic [1:0] MODE_CODE_IDLE     = 2'd0;
  localparam logic [1:0] MODE_CODE_STARTING = 2'd1;
  localparam logic [1:0] MODE_CODE_RUNNING  = 2'd2;
  localparam logic [1:0] MODE_CODE_FAULT    = 2'd3;

  localparam logic [2:0] FUNC_MS_TICK   = 3'd0;
  localparam logic [2:0] FUNC_RELOAD    = 3'd1;
  localparam logic [2:0] FUNC_CROSSING  = 3'd2;
  localparam logic [2:0] FUNC_START     = 3'd3;
  localparam logic [2:0] FUNC_STOP      = 3'd4;
  localparam logic [2:0] FUNC_SET_POWER = 3'd5;

  localparam logic [1:0] CFG_OPEN_LOOP_LIMIT = 2'd0;
  localparam logic [1:0] CFG_RAMP_INCREMENT  = 2'd1;
  localparam logic [1:0] CFG_STALL_LIMIT_MS  = 2'd2;

  localparam logic [15:0] OPEN_LOOP_LIMIT_RST = 16'd500;
  localparam logic [7:0]  RAMP_INCREMENT_RST  = 8'd2;
  localparam logic [15:0] STALL_LIMIT_MS_RST  = 16'd50;

  localparam logic [2:0]  PHASE_LAST = 3'd5;
  localparam logic [15:0] U16_MAX    = 16'hFFFF;

  typedef struct packed {
    logic [2:0]  func;
    logic        driver_fault;
    logic [7:0]  power_level;
    logic [15:0] initial_rate;
  } in_word_t;

  typedef struct packed {
    logic [1:0]  mode;
    logic [2:0]  phase;
    logic [7:0]  duty;
    logic [15:0] step_rate;
    logic        step_timer_on;
    logic        comparator_on;
    logic [1:0]  comparator_channel;
    logic        comparator_invert;
    logic        commutated;
  } out_word_t;

  typedef struct packed {
    logic [15:0] open_loop_limit;
    logic [7:0]  ramp_increment;
    logic [15:0] stall_limit_ms;
  } cfg_t;

  typedef struct packed {
    mode_e       mode;
    logic [2:0]  phase;
    logic [7:0]  power;
    logic [7:0]  duty;
    logic [15:0] rate;
    logic [15:0] since_ms;
    logic        timer_on;
    logic        comp_on;
  } ctrl_state_t;

  function automatic logic [1:0] mode_code(mode_e m);
    logic [1:0] c;
    unique case (m)
      MODE_IDLE:     c = MODE_CODE_IDLE;
      MODE_STARTING: c = MODE_CODE_STARTING;
      MODE_RUNNING:  c = MODE_CODE_RUNNING;
      MODE_FAULT:    c = MODE_CODE_FAULT;
      default:       c = MODE_CODE_IDLE;
    endcase
    return c;
  endfunction

  // floating phase to sense for each commutation phase
  function automatic logic [1:0] comp_channel(logic [2:0] phase);
    logic [1:0] ch;
    case (phase)
      3'd1, 3'd4: ch = 2'd2;
      3'd2, 3'd5: ch = 2'd1;
      default:    ch = 2'd0;
    endcase
    return ch;
  endfunction

  function automatic logic comp_invert(logic [2:0] phase);
    logic inv;
    case (phase)
      3'd0, 3'd2, 3'd4: inv = 1'b1;
      default:          inv = 1'b0;
    endcase
    return inv;
  endfunction

endpackage

/* rtl/core/bssc_cfg_regs.sv */
// Configuration registers for the six-step start-up controller.
`timescale 1ns / 1ps

module bssc_cfg_regs (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_valid_i,
  input  logic          cfg_ready_i,
  input  logic [1:0]    cfg_index_i,
  input  logic [15:0]   cfg_data_i,
  output bssc_pkg::cfg_t cfg_o
);
  import bssc_pkg::*;

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i && cfg_ready_i) begin
      case (cfg_index_i)
        CFG_OPEN_LOOP_LIMIT: cfg_d.open_loop_limit = cfg_data_i;
        CFG_RAMP_INCREMENT:  cfg_d.ramp_increment  = cfg_data_i[7:0];
        CFG_STALL_LIMIT_MS:  cfg_d.stall_limit_ms  = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.open_loop_limit <= OPEN_LOOP_LIMIT_RST;
      cfg_q.ramp_increment  <= RAMP_INCREMENT_RST;
      cfg_q.stall_limit_ms  <= STALL_LIMIT_MS_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

/* rtl/core/bssc_step.sv */
// Event logic: next controller state and result word for one input word.
`timescale 1ns / 1ps

module bssc_step (
  input  bssc_pkg::ctrl_state_t state_i,
  input  bssc_pkg::in_word_t    word_i,
  input  bssc_pkg::cfg_t        cfg_i,
  output bssc_pkg::ctrl_state_t state_o,
  output bssc_pkg::out_word_t   result_o
);
  import bssc_pkg::*;

  function automatic ctrl_state_t halt(ctrl_state_t st);
    ctrl_state_t h;
    h = st;
    h.timer_on = 1'b0;
    h.comp_on  = 1'b0;
    h.duty     = 8'd0;
    if (h.mode != MODE_FAULT) h.mode = MODE_IDLE;
    return h;
  endfunction

  function automatic logic [2:0] next_phase(logic [2:0] p);
    return (p >= PHASE_LAST) ? 3'd0 : p + 3'd1;
  endfunction

  ctrl_state_t s;
  logic        stepped;
  logic [16:0] rate_sum;

  always_comb begin
    s        = state_i;
    stepped  = 1'b0;
    rate_sum = {1'b0, state_i.rate} + {9'd0, cfg_i.ramp_increment};
    case (word_i.func)
      FUNC_MS_TICK: begin
        if (s.since_ms != U16_MAX) s.since_ms = s.since_ms + 16'd1;
        if (word_i.driver_fault) begin
          if (s.mode == MODE_STARTING || s.mode == MODE_RUNNING) s = halt(s);
          s.mode = MODE_FAULT;
        end else if (s.mode == MODE_FAULT) begin
          s.mode = MODE_IDLE;
        end else if (s.mode == MODE_RUNNING && s.since_ms > cfg_i.stall_limit_ms) begin
          s = halt(s);
        end
      end
      FUNC_RELOAD: begin
        if (s.timer_on) begin
          if (s.mode == MODE_STARTING) begin
            s.phase = next_phase(s.phase);
            stepped = 1'b1;
            if (s.rate < cfg_i.open_loop_limit) begin
              s.rate = rate_sum[16] ? U16_MAX : rate_sum[15:0];
            end else begin
              s.mode     = MODE_RUNNING;
              s.since_ms = 16'd0;
              s.comp_on  = 1'b1;
            end
          end else begin
            s.timer_on = 1'b0;
          end
        end
      end
      FUNC_CROSSING: begin
        if (s.comp_on) begin
          s.since_ms = 16'd0;
          s.phase    = next_phase(s.phase);
          stepped    = 1'b1;
        end
      end
      FUNC_START: begin
        if (s.mode == MODE_IDLE) begin
          s.since_ms = 16'd0;
          s.rate     = word_i.initial_rate;
          s.mode     = MODE_STARTING;
          s.duty     = s.power;
          s.timer_on = 1'b1;
        end
      end
      FUNC_STOP: s = halt(s);
      FUNC_SET_POWER: begin
        s.power = word_i.power_level;
        if (s.mode == MODE_STARTING || s.mode == MODE_RUNNING) s.duty = word_i.power_level;
      end
      default: ;
    endcase
  end

  assign state_o = s;

  always_comb begin
    result_o.mode               = mode_code(s.mode);
    result_o.phase              = s.phase;
    result_o.duty               = s.duty;
    result_o.step_rate          = s.rate;
    result_o.step_timer_on      = s.timer_on;
    result_o.comparator_on      = s.comp_on;
    result_o.comparator_channel = s.comp_on ? comp_channel(s.phase) : 2'd0;
    result_o.comparator_invert  = s.comp_on ? comp_invert(s.phase) : 1'b0;
    result_o.commutated         = stepped;
  end

endmodule

/* rtl/core/bldc_six_step_startup_controller_core.sv */
// Top level of the sensorless six-step BLDC start-up and run controller.
// Each input word is one event (ms tick, step-timer reload, zero crossing,
// start, stop, set power) and yields exactly one result word with the state
// after the event. One word is taken per clock cycle unless the input is
// stalled; an accepted word passes the input register, then the result
// register, which holds its result word. The input stalls only while the
// input register holds a word and the result register holds a word that
// the receiver is stalling. Configuration writes are always ready and apply
// to the next word processed; write only while no word is in flight.
`timescale 1ns / 1ps

module bldc_six_step_startup_controller_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  bssc_pkg::in_word_t  in_word_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output bssc_pkg::out_word_t out_word_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [1:0]          cfg_index_i,
  input  logic [15:0]         cfg_data_i
);
  import bssc_pkg::*;

  cfg_t        cfg;
  ctrl_state_t state_q, state_d;
  out_word_t   result;
  in_word_t    in_word_q;
  out_word_t   out_word_q;
  logic        in_valid_q, out_valid_q;
  logic        out_free, process;

  assign cfg_ready_o = 1'b1;

  bssc_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_i (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  bssc_step u_step (
    .state_i  (state_q),
    .word_i   (in_word_q),
    .cfg_i    (cfg),
    .state_o  (state_d),
    .result_o (result)
  );

  assign out_free   = !out_valid_q || !out_stall_i;
  assign process    = in_valid_q && out_free;
  assign in_stall_o = in_valid_q && !out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      state_q     <= '{mode: MODE_IDLE, default: '0};
    end else begin
      if (!in_stall_o) in_valid_q <= in_valid_i;
      if (out_free) out_valid_q <= in_valid_q;
      if (process) state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) in_word_q <= in_word_i;
    if (process) out_word_q <= result;
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

  a_phase_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.phase <= PHASE_LAST)
    else $error("phase out of range");

  a_duty_off_when_stopped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q.mode == MODE_IDLE || state_q.mode == MODE_FAULT) |-> state_q.duty == 8'd0)
    else $error("duty nonzero while stopped");

  a_comp_iff_running: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.comp_on == (state_q.mode == MODE_RUNNING))
    else $error("comparator armed state disagrees with mode");

  a_state_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !process |=> $stable(state_q))
    else $error("state changed without a word");

endmodule
